/* rtl/core/rks_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rks_pkg
// types, constants and helper functions shared by the keystream xor core
// ----------------------------------------------------------------------------
package rks_pkg;

    localparam int unsigned NWORDS = 8;
    localparam int unsigned NBYTES = 16;

    typedef logic [NWORDS-1:0][31:0] words_t;
    typedef logic [NBYTES*8-1:0]     block_t;

    typedef enum logic
    {
        MODE_RESTART = 1'b0,
        MODE_DATA    = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t      mode;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed
    {
        logic [7:0] data_out;
        logic       last_out;
        logic       keyed;
    } res_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_LOAD,
        BK_SQ,
        BK_FOLD,
        BK_MIX,
        BK_EXTR,
        BK_REINIT,
        BK_EMIT
    } bk_state_t;

    // counter increments, word 7 on the left
    localparam words_t ACON = {
        32'hD34D34D3, 32'h4D34D34D, 32'h34D34D34, 32'hD34D34D3,
        32'h4D34D34D, 32'h34D34D34, 32'hD34D34D3, 32'h4D34D34D
    };

    localparam logic [3:0] ADDR_KEY_LOW  = 4'h0;
    localparam logic [3:0] ADDR_KEY_HIGH = 4'h8;

    function automatic logic [31:0] rotl8(input logic [31:0] v);
        return {v[23:0], v[31:24]};
    endfunction

    function automatic logic [31:0] rotl16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    function automatic block_t extract(input words_t x);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        w0 = x[0] ^ {16'h0, x[5][31:16]} ^ {x[3][15:0], 16'h0};
        w1 = x[2] ^ {16'h0, x[7][31:16]} ^ {x[5][15:0], 16'h0};
        w2 = x[4] ^ {16'h0, x[1][31:16]} ^ {x[7][15:0], 16'h0};
        w3 = x[6] ^ {16'h0, x[3][31:16]} ^ {x[1][15:0], 16'h0};
        return {w3, w2, w1, w0};
    endfunction

endpackage

/* rtl/core/rabbit_keystream_xor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rabbit_keystream_xor_core
// rabbit stream cipher, 128-bit key, no iv: xors each data word with keystream
// ----------------------------------------------------------------------------
// usage
//   key_low at paddr 0x0 and key_high at 0x8 over the apb port, 64-bit data;
//   a write takes effect at the next restart word
//   input queue: push/full carry mode, data_byte, last_byte; mode 0 restarts
//   with the key, mode 1 xors data_byte with the next keystream byte
//   result queue: empty/pop carry data_out, last_out, keyed; one result word
//   per input word, in order
//   a word inside a keystream block goes straight to emit; the first byte of
//   each 16-byte block first runs a next-state iteration and an extraction,
//   and a restart runs the key load, the next-state iterations and the reinit;
//   one 32x32 squarer serves the eight g-function words in turn per iteration
//   two-entry queues on both sides: input is taken while a result waits; when
//   the receiver stops popping the engine holds its finished word and stalls
//   reset clears state, counters, key registers and both queues; keyed is 0
//   until the first restart
// ----------------------------------------------------------------------------
module rabbit_keystream_xor_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  data_out,
    output logic        last_out,
    output logic        keyed
);
    import rks_pkg::*;

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic        cfg_wr;
    item_t       in_item;
    item_t       item;
    logic        item_valid;
    logic        item_restart;
    logic        item_take;
    logic        res_wr;
    res_t        res;
    res_t        head;
    logic        res_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr)
            ADDR_KEY_LOW:  prdata = key_low_reg;
            ADDR_KEY_HIGH: prdata = key_high_reg;
            default:       prdata = 64'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= 64'h0;
            key_high_reg <= 64'h0;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_KEY_LOW)
            begin
                key_low_reg <= pwdata;
            end
            if (paddr == ADDR_KEY_HIGH)
            begin
                key_high_reg <= pwdata;
            end
        end
    end

    assign in_item.mode      = mode_t'(mode);
    assign in_item.data_byte = data_byte;
    assign in_item.last_byte = last_byte;

    rks_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_item      (in_item),
        .item_valid   (item_valid),
        .item_restart (item_restart),
        .item         (item),
        .item_take    (item_take)
    );

    rks_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          ({key_high_reg, key_low_reg}),
        .item_valid   (item_valid),
        .item_restart (item_restart),
        .item         (item),
        .item_take    (item_take),
        .res_wr       (res_wr),
        .res          (res),
        .res_full     (res_full)
    );

    rks_outq u_outq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_res  (res),
        .wr_full (res_full),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    assign data_out = head.data_out;
    assign last_out = head.last_out;
    assign keyed    = head.keyed;

endmodule

/* rtl/core/rks_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rks_front
// two-entry input queue; tags each word as restart or data for the back end
// ----------------------------------------------------------------------------
module rks_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  rks_pkg::item_t in_item,
    output logic           item_valid,
    output logic           item_restart,
    output rks_pkg::item_t item,
    input  logic           item_take
);
    import rks_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full         = (count_reg == 2'd2);
    assign item_valid   = (count_reg != 2'd0);
    assign do_wr        = push && !full;
    assign do_rd        = item_take && item_valid;
    assign item         = mem[rd_ptr_reg];
    assign item_restart = (mem[rd_ptr_reg].mode == MODE_RESTART);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/rks_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rks_outq
// two-entry result queue between the back end and the result port
// ----------------------------------------------------------------------------
module rks_outq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  rks_pkg::res_t wr_res,
    output logic          wr_full,
    output logic          empty,
    input  logic          pop,
    output rks_pkg::res_t head
);
    import rks_pkg::*;

    res_t       mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_full = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr && !wr_full;
    assign do_rd   = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/rks_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rks_back
// cipher engine: key setup, next-state iterations with one shared squarer,
// keystream extraction and the byte xor
// ----------------------------------------------------------------------------
module rks_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [127:0]   key,
    input  logic           item_valid,
    input  logic           item_restart,
    input  rks_pkg::item_t item,
    output logic           item_take,
    output logic           res_wr,
    output rks_pkg::res_t  res,
    input  logic           res_full
);
    import rks_pkg::*;

    bk_state_t   state_reg;
    bk_state_t   state_next;
    words_t      x_reg;
    words_t      x_next;
    words_t      c_reg;
    words_t      c_next;
    words_t      g_reg;
    words_t      g_next;
    logic        carry_reg;
    logic        carry_next;
    block_t      ks_reg;
    block_t      ks_next;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic        keyed_reg;
    logic        keyed_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic [1:0]  iter_reg;
    logic [1:0]  iter_next;
    logic [63:0] sq_reg;
    logic [63:0] sq_next;
    logic        rst_item_reg;
    logic        rst_item_next;
    logic [7:0]  dbyte_reg;
    logic [7:0]  dbyte_next;
    logic        last_reg;
    logic        last_next;
    logic [32:0] cnt_sum;
    logic [31:0] u_val;
    logic [15:0] k [NWORDS];

    always_comb
    begin
        for (int j = 0; j < NWORDS; j++)
        begin
            k[j] = key[16*j +: 16];
        end
    end

    // counter step and squarer input for the word being processed
    assign cnt_sum = {1'b0, c_reg[idx_reg]} + {1'b0, ACON[idx_reg]} + {32'h0, carry_reg};
    assign u_val   = x_reg[idx_reg] + cnt_sum[31:0];

    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        c_next        = c_reg;
        g_next        = g_reg;
        carry_next    = carry_reg;
        ks_next       = ks_reg;
        pos_next      = pos_reg;
        keyed_next    = keyed_reg;
        idx_next      = idx_reg;
        iter_next     = iter_reg;
        sq_next       = sq_reg;
        rst_item_next = rst_item_reg;
        dbyte_next    = dbyte_reg;
        last_next     = last_reg;
        item_take     = 1'b0;
        res_wr        = 1'b0;
        res.data_out  = rst_item_reg ? 8'h00 : (dbyte_reg ^ ks_reg[{pos_reg, 3'b000} +: 8]);
        res.last_out  = last_reg;
        res.keyed     = keyed_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    item_take     = 1'b1;
                    rst_item_next = item_restart;
                    dbyte_next    = item.data_byte;
                    last_next     = item.last_byte;
                    idx_next      = 3'd0;
                    if (item_restart)
                    begin
                        state_next = BK_LOAD;
                    end
                    else if (pos_reg == 4'd0)
                    begin
                        state_next = BK_SQ;
                    end
                    else
                    begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_LOAD:
            begin
                for (int j = 0; j < NWORDS; j++)
                begin
                    if ((j % 2) == 0)
                    begin
                        x_next[j] = {k[(j+1)%8], k[j]};
                        c_next[j] = {k[(j+4)%8], k[(j+5)%8]};
                    end
                    else
                    begin
                        x_next[j] = {k[(j+5)%8], k[(j+4)%8]};
                        c_next[j] = {k[j], k[(j+1)%8]};
                    end
                end
                carry_next = 1'b0;
                iter_next  = 2'd0;
                idx_next   = 3'd0;
                state_next = BK_SQ;
            end
            BK_SQ:
            begin
                c_next[idx_reg] = cnt_sum[31:0];
                carry_next      = cnt_sum[32];
                sq_next         = {32'h0, u_val} * {32'h0, u_val};
                state_next      = BK_FOLD;
            end
            BK_FOLD:
            begin
                g_next[idx_reg] = sq_reg[31:0] ^ sq_reg[63:32];
                idx_next        = idx_reg + 3'd1;
                state_next      = (idx_reg == 3'd7) ? BK_MIX : BK_SQ;
            end
            BK_MIX:
            begin
                for (int j = 0; j < NWORDS; j++)
                begin
                    if ((j % 2) == 0)
                    begin
                        x_next[j] = g_reg[j] + rotl16(g_reg[(j+7)%8])
                                    + rotl16(g_reg[(j+6)%8]);
                    end
                    else
                    begin
                        x_next[j] = g_reg[j] + rotl8(g_reg[(j+7)%8]) + g_reg[(j+6)%8];
                    end
                end
                if (rst_item_reg)
                begin
                    iter_next  = iter_reg + 2'd1;
                    state_next = (iter_reg == 2'd3) ? BK_REINIT : BK_SQ;
                end
                else
                begin
                    state_next = BK_EXTR;
                end
            end
            BK_EXTR:
            begin
                ks_next    = extract(x_reg);
                state_next = BK_EMIT;
            end
            BK_REINIT:
            begin
                for (int j = 0; j < NWORDS; j++)
                begin
                    c_next[j] = c_reg[j] ^ x_reg[(j+4)%8];
                end
                ks_next    = '0;
                pos_next   = 4'd0;
                keyed_next = 1'b1;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (!res_full)
                begin
                    res_wr     = 1'b1;
                    state_next = BK_IDLE;
                    if (!rst_item_reg)
                    begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        g_reg        <= g_next;
        sq_reg       <= sq_next;
        dbyte_reg    <= dbyte_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        iter_reg     <= iter_next;
        rst_item_reg <= rst_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            x_reg     <= '0;
            c_reg     <= '0;
            carry_reg <= 1'b0;
            ks_reg    <= '0;
            pos_reg   <= 4'd0;
            keyed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            c_reg     <= c_next;
            carry_reg <= carry_next;
            ks_reg    <= ks_next;
            pos_reg   <= pos_next;
            keyed_reg <= keyed_next;
        end
    end

endmodule

/* rtl/core/rks_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rks_assert
// port-level checks for the keystream xor core
// ----------------------------------------------------------------------------
module rks_assert
(
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       empty,
    input logic       pop,
    input logic [7:0] data_out,
    input logic       keyed
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // once a keyed word leaves, the next head word, if any, is keyed too
    a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && keyed) |=> (empty || keyed))
        else $error("keyed fell without reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(data_out)))
        else $error("stalled result word changed");

endmodule

bind rabbit_keystream_xor_core rks_assert u_rks_assert
(
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .empty    (empty),
    .pop      (pop),
    .data_out (data_out),
    .keyed    (keyed)
);
